// ===== hdl/sccal_pkg.sv =====
// Package: constants, reciprocal multipliers and month tables for the seconds clock calendar.
package sccal_pkg;

  localparam int NSTG = 14;

  localparam logic [1:0] FUNC_READ = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_SET  = 2'd2;

  localparam logic [2:0] WD_WED = 3'd3;
  localparam logic [2:0] WD_THU = 3'd4;
  localparam logic [2:0] WD_FRI = 3'd5;
  localparam logic [2:0] WD_SAT = 3'd6;
  localparam logic [2:0] WD_SUN = 3'd0;

  localparam logic [32:0] SECS_PER_DAY = 33'd86400;
  localparam logic [17:0] CIVIL_OFS    = 18'd146037;
  localparam logic [17:0] ERA_DAYS     = 18'd146097;
  localparam logic [17:0] DOE_LAST     = 18'd146096;
  localparam logic [17:0] CENT_1       = 18'd36524;
  localparam logic [17:0] CENT_2       = 18'd73048;
  localparam logic [17:0] CENT_3       = 18'd109572;
  localparam logic [15:0] WDAY_OFS     = 16'd10961;
  localparam logic [11:0] BASE_YEAR    = 12'd1600;
  localparam logic [11:0] ERA_YEARS    = 12'd400;
  localparam logic [11:0] NONLEAP_CENT = 12'd2100;

  // floor(x / d) = (x * M) >> S, exact for x < 2^w with S = w + bits(d)
  localparam int DAY_SHIFT = 35;
  localparam logic [25:0] DAY_MUL = 26'((64'd1 << DAY_SHIFT) / 64'd675 + 64'd1);
  localparam int MIN_SHIFT = 23;
  localparam logic [17:0] MIN_MUL = 18'((64'd1 << MIN_SHIFT) / 64'd60 + 64'd1);
  localparam int HOUR_SHIFT = 17;
  localparam logic [11:0] HOUR_MUL = 12'((64'd1 << HOUR_SHIFT) / 64'd60 + 64'd1);
  localparam int Q1460_SHIFT = 29;
  localparam logic [18:0] Q1460_MUL = 19'((64'd1 << Q1460_SHIFT) / 64'd1460 + 64'd1);
  localparam int Y365_SHIFT = 27;
  localparam logic [18:0] Y365_MUL = 19'((64'd1 << Y365_SHIFT) / 64'd365 + 64'd1);
  localparam int C100_SHIFT = 16;
  localparam logic [9:0] C100_MUL = 10'((64'd1 << C100_SHIFT) / 64'd100 + 64'd1);
  localparam int M153_SHIFT = 19;
  localparam logic [11:0] M153_MUL = 12'((64'd1 << M153_SHIFT) / 64'd153 + 64'd1);
  localparam int W7_SHIFT = 19;
  localparam logic [16:0] W7_MUL = 17'((64'd1 << W7_SHIFT) / 64'd7 + 64'd1);
  localparam int S7_SHIFT = 12;
  localparam logic [9:0] S7_MUL = 10'((64'd1 << S7_SHIFT) / 64'd7 + 64'd1);

  // days from March 1 to the first of month index mp (March is 0)
  function automatic logic [8:0] mar_offset(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd31;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd92;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd153;
      4'd6:  r = 9'd184;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd245;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd31;
      4'd2:  r = 9'd59;
      4'd3:  r = 9'd90;
      4'd4:  r = 9'd120;
      4'd5:  r = 9'd151;
      4'd6:  r = 9'd181;
      4'd7:  r = 9'd212;
      4'd8:  r = 9'd243;
      4'd9:  r = 9'd273;
      4'd10: r = 9'd304;
      4'd11: r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mi);
    logic [4:0] r;
    case (mi)
      4'd1:  r = 5'd28;
      4'd3:  r = 5'd30;
      4'd5:  r = 5'd30;
      4'd8:  r = 5'd30;
      4'd10: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/seconds_clock_calendar_unit.sv =====
// Seconds clock with calendar breakdown: count register and 14-stage date pipeline.
// Throughput: one item per cycle while out_stall is not holding the pipeline; the count register updates at acceptance.
// Pipeline stages advance independently; empty stages are filled under output stall.
// Reset (rst, synchronous) clears the count to zero and empties the pipeline.
module seconds_clock_calendar_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] new_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] seconds_count,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [4:0]  day,
  output logic [3:0]  month,
  output logic [11:0] year,
  output logic [2:0]  weekday,
  output logic [8:0]  day_of_year,
  output logic [4:0]  days_in_month,
  output logic [5:0]  week_number,
  output logic [11:0] week_year
);

  logic [31:0] seconds_total;
  logic [31:0] seconds_total_next;
  logic [sccal_pkg::NSTG-1:0] vld;
  logic [sccal_pkg::NSTG-1:0] rdy;
  logic acc;

  always_comb begin
    rdy[sccal_pkg::NSTG-1] = !vld[sccal_pkg::NSTG-1] || !out_stall;
    for (int k = sccal_pkg::NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall  = rst || !rdy[0];
  assign acc       = in_valid && !in_stall;
  assign out_valid = vld[sccal_pkg::NSTG-1];

  always_comb begin
    case (func)
      sccal_pkg::FUNC_READ: seconds_total_next = seconds_total;
      sccal_pkg::FUNC_TICK: seconds_total_next = seconds_total + 32'd1;
      sccal_pkg::FUNC_SET:  seconds_total_next = new_seconds;
      default:              seconds_total_next = seconds_total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_total <= 32'd0;
      vld <= '0;
    end else begin
      if (acc) seconds_total <= seconds_total_next;
      if (rdy[0]) vld[0] <= acc;
      for (int k = 1; k < sccal_pkg::NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage payloads
  logic [31:0] s1_secs, s2_secs, s3_secs, s4_secs, s5_secs, s6_secs, s7_secs;
  logic [31:0] s8_secs, s9_secs, s10_secs, s11_secs, s12_secs, s13_secs;
  logic [15:0] s2_days;
  logic [16:0] s3_rem, s4_rem;
  logic [17:0] s3_doe, s4_doe, s5_doe, s6_doe, s7_doe;
  logic        s3_era, s4_era, s5_era, s6_era, s7_era;
  logic [15:0] s3_wx, s4_wx;
  logic [10:0] s4_mins, s5_mins;
  logic [6:0]  s4_q1460;
  logic [2:0]  s4_q36524;
  logic        s4_full;
  logic [13:0] s4_wq;
  logic [5:0]  s5_sec, s6_sec, s7_sec, s8_sec, s9_sec, s10_sec, s11_sec, s12_sec, s13_sec;
  logic [4:0]  s5_hour, s6_hour, s7_hour, s8_hour, s9_hour, s10_hour, s11_hour, s12_hour;
  logic [4:0]  s13_hour;
  logic [17:0] s5_t;
  logic [2:0]  s5_wday, s6_wday, s7_wday, s8_wday, s9_wday, s10_wday, s11_wday, s12_wday;
  logic [2:0]  s13_wday;
  logic [5:0]  s6_min, s7_min, s8_min, s9_min, s10_min, s11_min, s12_min, s13_min;
  logic [8:0]  s6_yoe, s7_yoe;
  logic [17:0] s7_y365;
  logic [1:0]  s7_yq100;
  logic [8:0]  s8_doy, s9_doy;
  logic [11:0] s8_yrb, s9_yrb;
  logic [3:0]  s9_mp;
  logic [4:0]  s10_dd, s11_dd, s12_dd, s13_dd;
  logic [3:0]  s10_mm, s11_mm, s12_mm, s13_mm;
  logic [11:0] s10_yr, s11_yr, s12_yr, s13_yr;
  logic        s11_leap, s12_leap, s13_leap;
  logic        s11_leapp, s12_leapp, s13_leapp;
  logic [8:0]  s11_yday, s12_yday, s13_yday;
  logic [4:0]  s11_mdays, s12_mdays, s13_mdays;
  logic [8:0]  s12_jx, s13_jx;
  logic [8:0]  s12_wkx;
  logic [5:0]  s13_jq, s13_wk;

  // stage 2: day count
  logic [50:0] day_prod;
  assign day_prod = 51'(s1_secs[31:7]) * 51'(sccal_pkg::DAY_MUL);

  // stage 3: second of day, day of era, weekday operand
  logic [32:0] day_base;
  logic [17:0] zp;
  logic        era_c;
  assign day_base = 33'(s2_days) * sccal_pkg::SECS_PER_DAY;
  assign zp       = 18'(s2_days) + sccal_pkg::CIVIL_OFS;
  assign era_c    = zp >= sccal_pkg::ERA_DAYS;

  // stage 4: minute of day, leap corrections, weekday quotient
  logic [34:0] min_prod;
  logic [36:0] q1460_prod;
  logic [32:0] wq_prod;
  assign min_prod   = 35'(s3_rem) * 35'(sccal_pkg::MIN_MUL);
  assign q1460_prod = 37'(s3_doe) * 37'(sccal_pkg::Q1460_MUL);
  assign wq_prod    = 33'(s3_wx) * 33'(sccal_pkg::W7_MUL);

  // stage 5
  logic [22:0] hour_prod;
  assign hour_prod = 23'(s4_mins) * 23'(sccal_pkg::HOUR_MUL);

  // stage 6
  logic [36:0] yoe_prod;
  assign yoe_prod = 37'(s5_t) * 37'(sccal_pkg::Y365_MUL);

  // stage 7
  logic [18:0] yq_prod;
  assign yq_prod = 19'(s6_yoe) * 19'(sccal_pkg::C100_MUL);

  // stage 9
  logic [10:0] mpx;
  logic [22:0] mp_prod;
  assign mpx     = 11'(s8_doy) * 11'd5 + 11'd2;
  assign mp_prod = 23'(mpx) * 23'(sccal_pkg::M153_MUL);

  // stage 10
  logic [3:0] mm_c;
  assign mm_c = (s9_mp < 4'd10) ? s9_mp + 4'd3 : s9_mp - 4'd9;

  // stage 11: only 2000 and 2100 are centuries in range
  logic [11:0] yr_prev;
  logic        leap_c, leapp_c;
  logic [3:0]  mi_c;
  assign yr_prev = s10_yr - 12'd1;
  assign leap_c  = (s10_yr[1:0] == 2'd0) && (s10_yr != sccal_pkg::NONLEAP_CENT);
  assign leapp_c = (yr_prev[1:0] == 2'd0) && (yr_prev != sccal_pkg::NONLEAP_CENT);
  assign mi_c    = s10_mm - 4'd1;

  // stage 12
  logic [2:0] iso_wd;
  assign iso_wd = (s11_wday == sccal_pkg::WD_SUN) ? 3'd7 : s11_wday;

  // stage 13
  logic [18:0] jq_prod, wk_prod;
  assign jq_prod = 19'(s12_jx) * 19'(sccal_pkg::S7_MUL);
  assign wk_prod = 19'(s12_wkx) * 19'(sccal_pkg::S7_MUL);

  // stage 14: ISO week resolution from the weekday of January 1
  logic [2:0]  jan1;
  logic        w53_cur, w53_prev;
  logic [5:0]  week_c;
  logic [11:0] wyear_c;
  assign jan1     = 3'(s13_jx - 9'(s13_jq) * 9'd7);
  assign w53_cur  = (jan1 == sccal_pkg::WD_THU) || (s13_leap && jan1 == sccal_pkg::WD_WED);
  assign w53_prev = (jan1 == sccal_pkg::WD_FRI) || (s13_leapp && jan1 == sccal_pkg::WD_SAT);

  always_comb begin
    if (s13_wk == 6'd0) begin
      week_c  = w53_prev ? 6'd53 : 6'd52;
      wyear_c = s13_yr - 12'd1;
    end else if (s13_wk > (w53_cur ? 6'd53 : 6'd52)) begin
      week_c  = 6'd1;
      wyear_c = s13_yr + 12'd1;
    end else begin
      week_c  = s13_wk;
      wyear_c = s13_yr;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_secs <= seconds_total_next;
    end
    if (rdy[1]) begin
      s2_secs <= s1_secs;
      s2_days <= day_prod[sccal_pkg::DAY_SHIFT +: 16];
    end
    if (rdy[2]) begin
      s3_secs <= s2_secs;
      s3_rem  <= s2_secs[16:0] - day_base[16:0];
      s3_era  <= era_c;
      s3_doe  <= era_c ? zp - sccal_pkg::ERA_DAYS : zp;
      s3_wx   <= s2_days + sccal_pkg::WDAY_OFS;
    end
    if (rdy[3]) begin
      s4_secs   <= s3_secs;
      s4_rem    <= s3_rem;
      s4_mins   <= min_prod[sccal_pkg::MIN_SHIFT +: 11];
      s4_doe    <= s3_doe;
      s4_era    <= s3_era;
      s4_q1460  <= q1460_prod[sccal_pkg::Q1460_SHIFT +: 7];
      s4_q36524 <= 3'(s3_doe >= sccal_pkg::CENT_1) + 3'(s3_doe >= sccal_pkg::CENT_2)
                 + 3'(s3_doe >= sccal_pkg::CENT_3) + 3'(s3_doe >= sccal_pkg::DOE_LAST);
      s4_full   <= s3_doe == sccal_pkg::DOE_LAST;
      s4_wx     <= s3_wx;
      s4_wq     <= wq_prod[sccal_pkg::W7_SHIFT +: 14];
    end
    if (rdy[4]) begin
      s5_secs <= s4_secs;
      s5_sec  <= 6'(s4_rem - 17'(s4_mins) * 17'd60);
      s5_hour <= hour_prod[sccal_pkg::HOUR_SHIFT +: 5];
      s5_mins <= s4_mins;
      s5_t    <= s4_doe - 18'(s4_q1460) + 18'(s4_q36524) - 18'(s4_full);
      s5_wday <= 3'(s4_wx - 16'(s4_wq) * 16'd7);
      s5_doe  <= s4_doe;
      s5_era  <= s4_era;
    end
    if (rdy[5]) begin
      s6_secs <= s5_secs;
      s6_sec  <= s5_sec;
      s6_hour <= s5_hour;
      s6_min  <= 6'(s5_mins - 11'(s5_hour) * 11'd60);
      s6_wday <= s5_wday;
      s6_yoe  <= yoe_prod[sccal_pkg::Y365_SHIFT +: 9];
      s6_doe  <= s5_doe;
      s6_era  <= s5_era;
    end
    if (rdy[6]) begin
      s7_secs  <= s6_secs;
      s7_sec   <= s6_sec;
      s7_hour  <= s6_hour;
      s7_min   <= s6_min;
      s7_wday  <= s6_wday;
      s7_yoe   <= s6_yoe;
      s7_y365  <= 18'(s6_yoe) * 18'd365;
      s7_yq100 <= yq_prod[sccal_pkg::C100_SHIFT +: 2];
      s7_doe   <= s6_doe;
      s7_era   <= s6_era;
    end
    if (rdy[7]) begin
      s8_secs <= s7_secs;
      s8_sec  <= s7_sec;
      s8_hour <= s7_hour;
      s8_min  <= s7_min;
      s8_wday <= s7_wday;
      s8_doy  <= 9'(s7_doe - (s7_y365 + 18'(s7_yoe[8:2]) - 18'(s7_yq100)));
      s8_yrb  <= sccal_pkg::BASE_YEAR + (s7_era ? sccal_pkg::ERA_YEARS : 12'd0)
               + 12'(s7_yoe);
    end
    if (rdy[8]) begin
      s9_secs <= s8_secs;
      s9_sec  <= s8_sec;
      s9_hour <= s8_hour;
      s9_min  <= s8_min;
      s9_wday <= s8_wday;
      s9_doy  <= s8_doy;
      s9_yrb  <= s8_yrb;
      s9_mp   <= mp_prod[sccal_pkg::M153_SHIFT +: 4];
    end
    if (rdy[9]) begin
      s10_secs <= s9_secs;
      s10_sec  <= s9_sec;
      s10_hour <= s9_hour;
      s10_min  <= s9_min;
      s10_wday <= s9_wday;
      s10_dd   <= 5'(s9_doy - sccal_pkg::mar_offset(s9_mp) + 9'd1);
      s10_mm   <= mm_c;
      s10_yr   <= s9_yrb + 12'(mm_c <= 4'd2);
    end
    if (rdy[10]) begin
      s11_secs  <= s10_secs;
      s11_sec   <= s10_sec;
      s11_hour  <= s10_hour;
      s11_min   <= s10_min;
      s11_wday  <= s10_wday;
      s11_dd    <= s10_dd;
      s11_mm    <= s10_mm;
      s11_yr    <= s10_yr;
      s11_leap  <= leap_c;
      s11_leapp <= leapp_c;
      s11_yday  <= sccal_pkg::days_before(mi_c) + 9'(s10_dd)
                 + 9'(leap_c && s10_mm > 4'd2);
      s11_mdays <= sccal_pkg::month_len(mi_c) + 5'(leap_c && s10_mm == 4'd2);
    end
    if (rdy[11]) begin
      s12_secs  <= s11_secs;
      s12_sec   <= s11_sec;
      s12_hour  <= s11_hour;
      s12_min   <= s11_min;
      s12_wday  <= s11_wday;
      s12_dd    <= s11_dd;
      s12_mm    <= s11_mm;
      s12_yr    <= s11_yr;
      s12_leap  <= s11_leap;
      s12_leapp <= s11_leapp;
      s12_yday  <= s11_yday;
      s12_mdays <= s11_mdays;
      s12_jx    <= 9'(s11_wday) + 9'd372 - s11_yday;
      s12_wkx   <= s11_yday + 9'd10 - 9'(iso_wd);
    end
    if (rdy[12]) begin
      s13_secs  <= s12_secs;
      s13_sec   <= s12_sec;
      s13_hour  <= s12_hour;
      s13_min   <= s12_min;
      s13_wday  <= s12_wday;
      s13_dd    <= s12_dd;
      s13_mm    <= s12_mm;
      s13_yr    <= s12_yr;
      s13_leap  <= s12_leap;
      s13_leapp <= s12_leapp;
      s13_yday  <= s12_yday;
      s13_mdays <= s12_mdays;
      s13_jx    <= s12_jx;
      s13_jq    <= jq_prod[sccal_pkg::S7_SHIFT +: 6];
      s13_wk    <= wk_prod[sccal_pkg::S7_SHIFT +: 6];
    end
    if (rdy[13]) begin
      seconds_count <= s13_secs;
      second        <= s13_sec;
      minute        <= s13_min;
      hour          <= s13_hour;
      day           <= s13_dd;
      month         <= s13_mm;
      year          <= s13_yr;
      weekday       <= s13_wday;
      day_of_year   <= s13_yday;
      days_in_month <= s13_mdays;
      week_number   <= week_c;
      week_year     <= wyear_c;
    end
  end

`ifndef NO_ASSERTIONS
  a_tick: assert property (@(posedge clk) disable iff (rst)
    acc && func == sccal_pkg::FUNC_TICK |=> seconds_total == $past(seconds_total) + 32'd1)
    else $error("tick did not advance count");

  a_set: assert property (@(posedge clk) disable iff (rst)
    acc && func == sccal_pkg::FUNC_SET |=> seconds_total == $past(new_seconds))
    else $error("set did not load count");

  a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> second <= 6'd59 && minute <= 6'd59 && hour <= 5'd23
                  && day >= 5'd1 && day <= days_in_month && weekday <= 3'd6)
    else $error("time or date field out of range");

  a_iso: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> week_number >= 6'd1 && week_number <= 6'd53
                  && (week_year == year
                      || (week_year == year + 12'd1 && month == 4'd12)
                      || (week_year == year - 12'd1 && month == 4'd1)))
    else $error("ISO week inconsistent with date");
`endif

endmodule

// ===== tb/sccal_calendar_checker.sv =====
// Checker for the seconds clock calendar: tracks the count, predicts each date and compares.
module sccal_calendar_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] new_seconds,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] seconds_count,
  input  logic [5:0]  second,
  input  logic [5:0]  minute,
  input  logic [4:0]  hour,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [11:0] year,
  input  logic [2:0]  weekday,
  input  logic [8:0]  day_of_year,
  input  logic [4:0]  days_in_month,
  input  logic [5:0]  week_number,
  input  logic [11:0] week_year,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] count;
    logic [5:0]  sec;
    logic [5:0]  mins;
    logic [4:0]  hr;
    logic [4:0]  dom;
    logic [3:0]  mon;
    logic [11:0] yr;
    logic [2:0]  wd;
    logic [8:0]  yd;
    logic [4:0]  mlen;
    logic [5:0]  wk;
    logic [11:0] wk_yr;
  } civil_time_t;

  civil_time_t expected_dates[$];
  logic [31:0] clock_secs;

  function automatic int unsigned weeks_in_iso_year(input int unsigned y);
    int unsigned res_this;
    int unsigned res_prev;
    res_this = (y + y / 4 - y / 100 + y / 400) % 7;
    res_prev = ((y - 1) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400) % 7;
    return (res_this == 4 || res_prev == 3) ? 53 : 52;
  endfunction

  function automatic civil_time_t calendar_of(input logic [31:0] secs);
    int unsigned days, rem, unix_days, z, era, doe, yoe, y, doy, mp, d, m;
    int unsigned wd, yd, mlen, iso_wd, wk, wk_y;
    bit leap;
    civil_time_t c;
    days = secs / 86400;
    rem = secs % 86400;
    unix_days = days + 10957;
    z = unix_days + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = (mp < 10) ? mp + 3 : mp - 9;
    if (m <= 2) y = y + 1;
    wd = (unix_days + 4) % 7;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    // doy counts from March 1; Jan and Feb sit at its tail
    if (m > 2) yd = doy + 60 + int'(leap);
    else yd = doy - 305;
    case (m)
      2: mlen = 28 + int'(leap);
      4, 6, 9, 11: mlen = 30;
      default: mlen = 31;
    endcase
    iso_wd = (wd == int'(sccal_pkg::WD_SUN)) ? 7 : wd;
    wk = (yd + 10 - iso_wd) / 7;
    if (wk < 1) begin
      wk_y = y - 1;
      wk = weeks_in_iso_year(wk_y);
    end else if (wk > weeks_in_iso_year(y)) begin
      wk_y = y + 1;
      wk = 1;
    end else begin
      wk_y = y;
    end
    c.count = secs;
    c.sec   = 6'(rem % 60);
    c.mins  = 6'((rem % 3600) / 60);
    c.hr    = 5'(rem / 3600);
    c.dom   = 5'(d);
    c.mon   = 4'(m);
    c.yr    = 12'(y);
    c.wd    = 3'(wd);
    c.yd    = 9'(yd);
    c.mlen  = 5'(mlen);
    c.wk    = 6'(wk);
    c.wk_yr = 12'(wk_y);
    return c;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    civil_time_t e;
    if (rst) begin
      clock_secs = '0;
      expected_dates.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (func == sccal_pkg::FUNC_TICK) clock_secs = clock_secs + 32'd1;
        else if (func == sccal_pkg::FUNC_SET) clock_secs = new_seconds;
        expected_dates.push_back(calendar_of(clock_secs));
      end
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          $error("unexpected result item, seconds_count %0d", seconds_count);
          fail_count++;
        end else begin
          e = expected_dates.pop_front();
          check_field("seconds_count", e.count, seconds_count);
          check_field("second", e.sec, second);
          check_field("minute", e.mins, minute);
          check_field("hour", e.hr, hour);
          check_field("day", e.dom, day);
          check_field("month", e.mon, month);
          check_field("year", e.yr, year);
          check_field("weekday", e.wd, weekday);
          check_field("day_of_year", e.yd, day_of_year);
          check_field("days_in_month", e.mlen, days_in_month);
          check_field("week_number", e.wk, week_number);
          check_field("week_year", e.wk_yr, week_year);
        end
      end
    end
    outstanding = expected_dates.size();
  end

endmodule

// ===== tb/seconds_clock_calendar_unit_tb.sv =====
// Testbench top for the seconds clock calendar: clock, reset, stimulus and verdict.
module seconds_clock_calendar_unit_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = sccal_pkg::FUNC_READ;
  logic [31:0] new_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] seconds_count;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [11:0] year;
  logic [2:0]  weekday;
  logic [8:0]  day_of_year;
  logic [4:0]  days_in_month;
  logic [5:0]  week_number;
  logic [11:0] week_year;
  int          fail_count;
  int          outstanding;
  bit          quiet = 1'b0;
  int          stall_left = 0;

  seconds_clock_calendar_unit dut (.*);

  sccal_calendar_checker checker_i (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("seconds_clock_calendar_unit_tb NOT OK");
    $finish;
  end

  // result side backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_item(input logic [1:0] f, input logic [31:0] ns);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    new_seconds <= ns;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // days from 2000-01-01 to January 1 of year 2000 + k
  function automatic int unsigned jan1_days(input int unsigned k);
    return 365 * k + (k + 3) / 4 - (k + 99) / 100 + (k + 399) / 400;
  endfunction

  initial begin
    int unsigned r;
    logic [1:0]  f;
    logic [31:0] ns;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: reset date, wrap, ignored operand, leap days, year and ISO week edges
    push_item(sccal_pkg::FUNC_READ, 32'hFFFF_FFFF);
    push_item(sccal_pkg::FUNC_TICK, 32'h0000_0000);
    push_item(sccal_pkg::FUNC_SET, 32'hFFFF_FFFF);
    push_item(sccal_pkg::FUNC_TICK, 32'hAAAA_5555);
    push_item(FUNC_UNUSED, 32'h1234_5678);
    push_item(sccal_pkg::FUNC_READ, 32'h5555_AAAA);
    push_item(sccal_pkg::FUNC_SET, 32'd5097599);
    push_item(sccal_pkg::FUNC_TICK, 32'd0);
    push_item(sccal_pkg::FUNC_TICK, 32'hFFFF_FFFF);
    push_item(sccal_pkg::FUNC_SET, 32'd31535999);
    push_item(sccal_pkg::FUNC_TICK, 32'd0);
    push_item(sccal_pkg::FUNC_SET, 32'd3160857599);
    push_item(sccal_pkg::FUNC_TICK, 32'd0);
    push_item(sccal_pkg::FUNC_SET, 32'(1826 * 86400));
    push_item(sccal_pkg::FUNC_SET, 32'(1827 * 86400));
    push_item(sccal_pkg::FUNC_SET, 32'(3285 * 86400));
    push_item(sccal_pkg::FUNC_SET, 32'd86399);
    push_item(sccal_pkg::FUNC_TICK, 32'd0);
    push_item(sccal_pkg::FUNC_SET, 32'd4291747200);
    push_item(FUNC_UNUSED, 32'hFFFF_FFFF);
    push_item(sccal_pkg::FUNC_SET, 32'd0);
    push_item(sccal_pkg::FUNC_READ, 32'd0);

    for (int n = 0; n < 500; n++) begin
      quiet = (n >= 400);
      r = $urandom_range(0, 99);
      ns = $urandom;
      if (r < 40) begin
        f = sccal_pkg::FUNC_TICK;
      end else if (r < 55) begin
        f = sccal_pkg::FUNC_READ;
      end else if (r < 62) begin
        f = FUNC_UNUSED;
      end else begin
        f = sccal_pkg::FUNC_SET;
        case ($urandom_range(0, 3))
          0: ns = $urandom;
          1: ns = 32'($urandom_range(0, 49710)) * 32'd86400 + 32'd86400
                  - 32'($urandom_range(1, 4));
          2: ns = 32'(jan1_days($urandom_range(0, 136))) * 32'd86400
                  + 32'($urandom_range(0, 8 * 86400)) - 32'(4 * 86400);
          default: ns = 32'(jan1_days($urandom_range(0, 136))) * 32'd86400
                  - 32'($urandom_range(1, 3));
        endcase
      end
      push_item(f, ns);
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("seconds_clock_calendar_unit_tb OK");
    end else begin
      $display("seconds_clock_calendar_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
